// File: rtl/change_stamp_debouncer_core_assert.svh
// Assertion macros used by the change stamp debouncer engine.
`ifndef CHANGE_STAMP_DEBOUNCER_CORE_ASSERT_SVH
`define CHANGE_STAMP_DEBOUNCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/csd_pkg.sv
`default_nettype none

package csd_pkg;

	localparam int TIME_W     = 32;
	localparam int DEBOUNCE_W = 13;
	localparam int COOLDOWN_W = 14;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 13'd350;
	localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET = 14'd1200;

	typedef enum logic [1:0] {
		OP_POLL        = 2'd0,
		OP_SWITCH_HOLD = 2'd1,
		OP_WRITE_HOLD  = 2'd2,
		OP_REARM       = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_NO_STAMP       = 4'd0,
		ST_SWITCH_HOLD    = 4'd1,
		ST_WRITE_HOLD     = 4'd2,
		ST_BASELINE       = 4'd3,
		ST_UNCHANGED      = 4'd4,
		ST_DEBOUNCE_START = 4'd5,
		ST_WAITING        = 4'd6,
		ST_COOLDOWN       = 4'd7,
		ST_TRIGGERED      = 4'd8,
		ST_CMD_DONE       = 4'd9
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 1'b0,
		CFG_COOLDOWN = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		op_t               op;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] hold_ms;
	} in_item_t;

	typedef struct packed {
		status_t status;
		logic    trigger;
	} out_item_t;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] debounce_ms;
		logic [COOLDOWN_W-1:0] cooldown_ms;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/csd_cfg_regs.sv
`default_nettype none

module csd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [csd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csd_pkg::CFG_DATA_W-1:0] cfg_data,
	output csd_pkg::cfg_t                  cfg
);

	csd_pkg::cfg_t cfg_q;

	// Register file write; writes are always taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= csd_pkg::DEBOUNCE_RESET;
			cfg_q.cooldown_ms <= csd_pkg::COOLDOWN_RESET;
		end else if (cfg_valid) begin
			unique case (csd_pkg::cfg_reg_t'(cfg_index))
				csd_pkg::CFG_DEBOUNCE: begin
					cfg_q.debounce_ms <= cfg_data[csd_pkg::DEBOUNCE_W-1:0];
				end
				csd_pkg::CFG_COOLDOWN: begin
					cfg_q.cooldown_ms <= cfg_data[csd_pkg::COOLDOWN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/csd_engine.sv
`default_nettype none

module csd_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  csd_pkg::in_item_t  item,
	input  csd_pkg::cfg_t      cfg,
	output csd_pkg::out_item_t result
);

	logic [csd_pkg::TIME_W-1:0] baseline_q, baseline_d;
	logic [csd_pkg::TIME_W-1:0] pending_q, pending_d;
	logic [csd_pkg::TIME_W-1:0] since_q, since_d;
	logic [csd_pkg::TIME_W-1:0] last_trig_q, last_trig_d;
	logic [csd_pkg::TIME_W-1:0] sw_hold_q, sw_hold_d;
	logic [csd_pkg::TIME_W-1:0] wr_hold_q, wr_hold_d;

	logic                       sw_open, wr_open;
	logic                       debounce_wait, cooldown_wait;
	logic [csd_pkg::TIME_W-1:0] pend_age, trig_age;
	csd_pkg::status_t           status;

	// Window checks by plain unsigned compare; age checks modulo 2^32
	assign sw_open       = item.now_ms < sw_hold_q;
	assign wr_open       = item.now_ms < wr_hold_q;
	assign pend_age      = item.now_ms - since_q;
	assign trig_age      = item.now_ms - last_trig_q;
	assign debounce_wait = pend_age < csd_pkg::TIME_W'(cfg.debounce_ms);
	assign cooldown_wait = trig_age < csd_pkg::TIME_W'(cfg.cooldown_ms);

	// Decision and next state for the item in flight
	always_comb begin
		baseline_d  = baseline_q;
		pending_d   = pending_q;
		since_d     = since_q;
		last_trig_d = last_trig_q;
		sw_hold_d   = sw_hold_q;
		wr_hold_d   = wr_hold_q;
		status      = csd_pkg::ST_CMD_DONE;
		unique case (item.op)
			csd_pkg::OP_POLL: begin
				if (item.stamp == '0) begin
					status = csd_pkg::ST_NO_STAMP;
				end else if (sw_open || wr_open) begin
					// hold open: follow the stamp silently
					baseline_d = item.stamp;
					pending_d  = '0;
					since_d    = '0;
					status     = sw_open ? csd_pkg::ST_SWITCH_HOLD : csd_pkg::ST_WRITE_HOLD;
				end else if (baseline_q == '0) begin
					baseline_d = item.stamp;
					status     = csd_pkg::ST_BASELINE;
				end else if (item.stamp == baseline_q) begin
					pending_d = '0;
					since_d   = '0;
					status    = csd_pkg::ST_UNCHANGED;
				end else if (item.stamp != pending_q) begin
					pending_d = item.stamp;
					since_d   = item.now_ms;
					status    = csd_pkg::ST_DEBOUNCE_START;
				end else if (debounce_wait) begin
					status = csd_pkg::ST_WAITING;
				end else if (cooldown_wait) begin
					status = csd_pkg::ST_COOLDOWN;
				end else begin
					baseline_d  = item.stamp;
					pending_d   = '0;
					since_d     = '0;
					last_trig_d = item.now_ms;
					status      = csd_pkg::ST_TRIGGERED;
				end
			end
			csd_pkg::OP_SWITCH_HOLD: begin
				sw_hold_d = item.now_ms + item.hold_ms;
			end
			csd_pkg::OP_WRITE_HOLD: begin
				wr_hold_d = item.now_ms + item.hold_ms;
			end
			csd_pkg::OP_REARM: begin
				baseline_d  = '0;
				pending_d   = '0;
				since_d     = '0;
				last_trig_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign result.status  = status;
	assign result.trigger = (status == csd_pkg::ST_TRIGGERED);

	// Debounce state, updated once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q  <= '0;
			pending_q   <= '0;
			since_q     <= '0;
			last_trig_q <= '0;
			sw_hold_q   <= '0;
			wr_hold_q   <= '0;
		end else if (fire) begin
			baseline_q  <= baseline_d;
			pending_q   <= pending_d;
			since_q     <= since_d;
			last_trig_q <= last_trig_d;
			sw_hold_q   <= sw_hold_d;
			wr_hold_q   <= wr_hold_d;
		end
	end

`include "change_stamp_debouncer_core_assert.svh"

	`CSD_ASSERT_NXT(a_trig_time, clk, arst_n, fire && result.trigger,
		last_trig_q == $past(item.now_ms), "trigger time not recorded")
	`CSD_ASSERT_NXT(a_pend_load, clk, arst_n,
		fire && (result.status == csd_pkg::ST_DEBOUNCE_START),
		(pending_q == $past(item.stamp)) && (since_q == $past(item.now_ms)),
		"pending stamp not loaded")
	`CSD_ASSERT_IMP(a_pend_vs_base, clk, arst_n, pending_q != '0,
		(baseline_q != '0) && (pending_q != baseline_q), "pending stamp inconsistent")
	`CSD_ASSERT_NXT(a_idle_hold, clk, arst_n, !fire,
		$stable(baseline_q) && $stable(pending_q) && $stable(last_trig_q),
		"state moved without an item")

endmodule

`default_nettype wire

// File: rtl/change_stamp_debouncer_core.sv
`default_nettype none

// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------
// in       in_valid / in_ready    in_item  (op, now_ms, stamp, hold_ms)
// out      out_valid / out_ready  out_item (status, trigger)
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out_ready stays high; an accepted item
// passes the input register, then the result register, which presents it;
// an output stall can hold it in either register.
// cfg_ready is always high; a write takes effect at the edge of its transfer.
// Reset clears the debounce state and loads debounce 350 ms, cooldown 1200 ms.
// An output stall holds the result register; in_ready stays high until the
// input register also holds an item, then stays low until the result drains.

module change_stamp_debouncer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  csd_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output csd_pkg::out_item_t             out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [csd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csd_pkg::CFG_DATA_W-1:0] cfg_data
);

	csd_pkg::in_item_t  item_s1;
	logic               valid_s1;
	csd_pkg::out_item_t result_s2;
	logic               valid_s2;
	csd_pkg::out_item_t result;
	csd_pkg::cfg_t      cfg;
	logic               advance;

	// Item moves to the result register when that register is free or draining
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	csd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	csd_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = result_s2;

endmodule

`default_nettype wire

// File: sim/csd_result_checker.sv
module csd_result_checker
	import csd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_item,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_item,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    outstanding,
	output int                    results_seen,
	output int                    triggers_seen,
	output logic [9:0]            status_seen
);

	localparam int NUM_STATUS = 10;
	localparam int MAX_REPORTS = 200;

	// Shadow copy of the timing registers and debounce state
	logic [DEBOUNCE_W-1:0] debounce_ms;
	logic [COOLDOWN_W-1:0] cooldown_ms;
	logic [TIME_W-1:0]     baseline;
	logic [TIME_W-1:0]     pend_stamp;
	logic [TIME_W-1:0]     pend_since;
	logic [TIME_W-1:0]     last_fire;
	logic [TIME_W-1:0]     switch_until;
	logic [TIME_W-1:0]     write_until;

	// Expected results, oldest first
	out_item_t status_forecast[$];

	int                    err_cnt;
	int                    result_cnt;
	int                    trig_cnt;
	logic [NUM_STATUS-1:0] seen;

	assign errors        = err_cnt;
	assign results_seen  = result_cnt;
	assign triggers_seen = trig_cnt;
	assign status_seen   = seen;

	task automatic drop_pending();
		pend_stamp = '0;
		pend_since = '0;
	endtask

	// Advance the shadow state by one item and return the status it earns
	task automatic debounce_step(input in_item_t it, output out_item_t res);
		logic [TIME_W-1:0] since_change;
		logic [TIME_W-1:0] since_fire;
		status_t           st;
		since_change = it.now_ms - pend_since;
		since_fire   = it.now_ms - last_fire;
		st = ST_CMD_DONE;
		case (it.op)
			OP_POLL: begin
				if (it.stamp == '0) begin
					st = ST_NO_STAMP;
				end else if (it.now_ms < switch_until) begin
					baseline = it.stamp;
					drop_pending();
					st = ST_SWITCH_HOLD;
				end else if (it.now_ms < write_until) begin
					baseline = it.stamp;
					drop_pending();
					st = ST_WRITE_HOLD;
				end else if (baseline == '0) begin
					baseline = it.stamp;
					st = ST_BASELINE;
				end else if (it.stamp == baseline) begin
					drop_pending();
					st = ST_UNCHANGED;
				end else if (it.stamp != pend_stamp) begin
					pend_stamp = it.stamp;
					pend_since = it.now_ms;
					st = ST_DEBOUNCE_START;
				end else if (since_change < TIME_W'(debounce_ms)) begin
					st = ST_WAITING;
				end else if (since_fire < TIME_W'(cooldown_ms)) begin
					st = ST_COOLDOWN;
				end else begin
					baseline = it.stamp;
					drop_pending();
					last_fire = it.now_ms;
					st = ST_TRIGGERED;
				end
			end
			OP_SWITCH_HOLD: switch_until = it.now_ms + it.hold_ms;
			OP_WRITE_HOLD:  write_until = it.now_ms + it.hold_ms;
			default: begin
				// rearm: hold windows survive
				baseline = '0;
				drop_pending();
				last_fire = '0;
			end
		endcase
		res.status  = st;
		res.trigger = (st == ST_TRIGGERED);
	endtask

	// Watch all three channels; config first, then results, then new inputs
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t pred;
		if (!arst_n) begin
			debounce_ms  = DEBOUNCE_RESET;
			cooldown_ms  = COOLDOWN_RESET;
			baseline     = '0;
			pend_stamp   = '0;
			pend_since   = '0;
			last_fire    = '0;
			switch_until = '0;
			write_until  = '0;
			status_forecast.delete();
			err_cnt      = 0;
			result_cnt   = 0;
			trig_cnt     = 0;
			seen         = '0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEBOUNCE: debounce_ms = cfg_data[DEBOUNCE_W-1:0];
					CFG_COOLDOWN: cooldown_ms = cfg_data[COOLDOWN_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				result_cnt++;
				if (out_item.status < NUM_STATUS)
					seen[out_item.status] = 1'b1;
				if (out_item.trigger === 1'b1)
					trig_cnt++;
				if (status_forecast.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: stray result: expected none, actual status %0d trigger %b",
							$time, out_item.status, out_item.trigger);
				end else begin
					want = status_forecast.pop_front();
					if (out_item.status !== want.status) begin
						err_cnt++;
						if (err_cnt <= MAX_REPORTS)
							$display("%0t: status mismatch: expected %0d (%s), actual %0d",
								$time, want.status, want.status.name(), out_item.status);
					end
					if (out_item.trigger !== want.trigger) begin
						err_cnt++;
						if (err_cnt <= MAX_REPORTS)
							$display("%0t: trigger mismatch: expected %b, actual %b",
								$time, want.trigger, out_item.trigger);
					end
				end
			end

			if (in_valid && in_ready) begin
				debounce_step(in_item, pred);
				status_forecast.push_back(pred);
			end

			outstanding <= status_forecast.size();
		end
	end

endmodule

// File: sim/tb_change_stamp_debouncer_core.sv
module tb_change_stamp_debouncer_core;
	import csd_pkg::*;

	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 190;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 500000;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int         errors;
	int         outstanding;
	int         results_seen;
	int         triggers_seen;
	logic [9:0] status_seen;

	// Run-wide stimulus state
	bit                quiet      = 1'b0;
	int                stall_left = 0;
	int                cycles     = 0;
	logic [TIME_W-1:0] clock_ms   = '0;
	logic [TIME_W-1:0] file_stamp = 32'h0000_1234;
	logic [TIME_W-1:0] prev_stamp = 32'h0000_1234;

	change_stamp_debouncer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	csd_result_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_item       (in_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_item      (out_item),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.outstanding   (outstanding),
		.results_seen  (results_seen),
		.triggers_seen (triggers_seen),
		.status_seen   (status_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
			$display("** change_stamp_debouncer_core: FAILED **");
			$finish;
		end
	end

	// Result side back-pressure: random stalls, off while quiet
	always @(posedge clk) begin
		if (quiet) begin
			stall_left <= 0;
			out_ready  <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 15);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// One input transfer, with an occasional idle burst ahead of it
	task automatic send_item(input in_item_t it);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_fields(input op_t op, input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] stamp, input logic [TIME_W-1:0] hold);
		in_item_t it;
		it.op      = op;
		it.now_ms  = now;
		it.stamp   = stamp;
		it.hold_ms = hold;
		send_item(it);
	endtask

	// Stop sending and wait until every expected result has been taken
	task automatic wait_until_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic write_timing(input int unsigned deb, input int unsigned cool);
		write_register(CFG_DEBOUNCE, CFG_DATA_W'(deb));
		write_register(CFG_COOLDOWN, CFG_DATA_W'(cool));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [TIME_W-1:0] pick_hold();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return $urandom_range(0, 1500);
		else if (roll < 9)
			return $urandom_range(0, 20000);
		return $urandom();
	endfunction

	// Mostly a stamp held over several polls while time creeps forward,
	// with changes, zero stamps, returns to the old stamp and stray values
	task automatic make_random_item(output in_item_t it);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			clock_ms = $urandom();
		else if (roll < 4)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
		else if (roll < 12)
			clock_ms = clock_ms + $urandom_range(0, 4000);
		else
			clock_ms = clock_ms + $urandom_range(0, 400);
		it.now_ms  = clock_ms;
		it.stamp   = $urandom();
		it.hold_ms = $urandom();

		roll = $urandom_range(0, 99);
		if (roll < 82) begin
			it.op = OP_POLL;
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				prev_stamp = file_stamp;
				file_stamp = $urandom();
				it.stamp   = file_stamp;
			end else if (roll < 18) begin
				it.stamp = '0;
			end else if (roll < 25) begin
				it.stamp = prev_stamp;
			end else if (roll >= 30) begin
				it.stamp = file_stamp;
			end
		end else if (roll < 87) begin
			it.op      = OP_SWITCH_HOLD;
			it.hold_ms = pick_hold();
		end else if (roll < 92) begin
			it.op      = OP_WRITE_HOLD;
			it.hold_ms = pick_hold();
		end else if (roll < 95) begin
			it.op = OP_REARM;
		end else begin
			// close one window right away
			it.op      = $urandom_range(0, 1) ? OP_SWITCH_HOLD : OP_WRITE_HOLD;
			it.hold_ms = '0;
		end
	endtask

	initial begin
		int unsigned deb_set [NUM_PHASES];
		int unsigned cool_set [NUM_PHASES];
		in_item_t    it;

		// phase 0 runs on the reset values
		deb_set[0] = DEBOUNCE_RESET;  cool_set[0] = COOLDOWN_RESET;
		deb_set[1] = 50;              cool_set[1] = 100;
		deb_set[2] = 5000;            cool_set[2] = 10000;
		deb_set[3] = 0;               cool_set[3] = 0;
		deb_set[4] = 16383;           cool_set[4] = 16383;
		deb_set[5] = $urandom_range(50, 5000);
		cool_set[5] = $urandom_range(100, 10000);
		deb_set[6] = $urandom_range(0, 16383);
		cool_set[6] = $urandom_range(0, 16383);
		deb_set[7] = 350;             cool_set[7] = 1200;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through every status under the reset timing
		send_fields(OP_POLL, 100, 32'h0, 32'h0);                 // no stamp
		send_fields(OP_POLL, 100, 32'h1, 32'hFFFF_FFFF);         // first baseline
		send_fields(OP_POLL, 150, 32'h1, 32'h0);                 // unchanged
		send_fields(OP_POLL, 200, 32'h8000_0000, 32'h0);         // debounce start
		send_fields(OP_POLL, 300, 32'h8000_0000, 32'h0);         // waiting
		send_fields(OP_POLL, 600, 32'h8000_0000, 32'h0);         // cooldown from tick 0
		send_fields(OP_POLL, 1300, 32'h8000_0000, 32'h0);        // fires
		send_fields(OP_POLL, 1400, 32'h5555_5555, 32'h0);
		send_fields(OP_POLL, 1800, 32'h5555_5555, 32'h0);        // cooldown after a fire
		send_fields(OP_POLL, 2600, 32'h5555_5555, 32'h0);        // fires again
		send_fields(OP_SWITCH_HOLD, 2700, 32'hFFFF_FFFF, 500);
		send_fields(OP_POLL, 2800, 32'hAAAA_AAAA, 32'h0);        // switch hold open
		send_fields(OP_WRITE_HOLD, 3300, 32'h0, 400);
		send_fields(OP_POLL, 3400, 32'h0000_BEEF, 32'h0);        // write hold open
		send_fields(OP_POLL, 3800, 32'h0000_BEEF, 32'h0);        // both closed
		send_fields(OP_REARM, 3900, 32'h0, 32'hFFFF_FFFF);
		send_fields(OP_POLL, 3950, 32'h0000_00F0, 32'h0);        // baseline after rearm
		send_fields(OP_SWITCH_HOLD, 32'hFFFF_FF00, 32'h0, 32'h200); // end wraps low
		send_fields(OP_POLL, 32'hFFFF_FF10, 32'h0F0F_0F0F, 32'h0);
		send_fields(OP_POLL, 32'h0000_1000, 32'h0F0F_0F0F, 32'h0);  // debounce across wrap
		send_fields(OP_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_fields(OP_WRITE_HOLD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_fields(OP_POLL, 32'h0000_0010, 32'h0000_0002, 32'h0); // long write hold
		send_fields(OP_WRITE_HOLD, 32'h0, 32'h0, 32'h0);         // close it

		// Random phases, each with its own timing; the last one without idling
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) begin
				wait_until_idle();
				if (ph == NUM_PHASES - 1)
					quiet <= 1'b1;
				write_timing(deb_set[ph], cool_set[ph]);
			end
			repeat (PHASE_ITEMS) begin
				make_random_item(it);
				send_item(it);
			end
		end
		wait_until_idle();

		$display("Covered %0d results with %0d triggers over %0d timing settings",
			results_seen, triggers_seen, NUM_PHASES);
		$display("(reset, range ends, zero, all-ones, random); status codes seen %b",
			status_seen);
		if (errors == 0) begin
			$display("** change_stamp_debouncer_core: PASSED **");
		end else begin
			$display("%0d mismatches", errors);
			$display("** change_stamp_debouncer_core: FAILED **");
		end
		$finish;
	end

endmodule
